FILE: hdl/svxhc_pkg.sv
// Shared constants, status codes and controller/datapath interface types.
package svxhc_pkg;

  // Header layout
  localparam int unsigned SCAN_BYTES = 150;
  localparam int unsigned SCAN_START = 40;
  localparam logic [7:0]  SCAN_END   = 8'(SCAN_START + SCAN_BYTES);
  localparam logic [7:0]  TAG_FIRST  = 8'(SCAN_START + 3);
  localparam logic [7:0]  POS_MAX    = 8'd255;

  // Tags, big-endian
  localparam logic [31:0] TAG_FORM = 32'h464F524D;
  localparam logic [31:0] TAG_8SVX = 32'h38535658;
  localparam logic [31:0] TAG_VHDR = 32'h56484452;
  localparam logic [31:0] TAG_CHAN = 32'h4348414E;
  localparam logic [31:0] TAG_BODY = 32'h424F4459;

  // Configuration
  localparam logic      CFG_TICK_RATE  = 1'b0;
  localparam logic      CFG_MIN_PERIOD = 1'b1;
  localparam logic [23:0] TICK_RATE_RST  = 24'd3546895;
  localparam logic [15:0] MIN_PERIOD_RST = 16'd124;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_IFF    = 3'd1;
  localparam logic [2:0] ST_NOT_8SVX   = 3'd2;
  localparam logic [2:0] ST_COMPRESSED = 3'd3;
  localparam logic [2:0] ST_OCTAVE     = 3'd4;
  localparam logic [2:0] ST_BAD_LAYOUT = 3'd5;

  localparam int unsigned DIV_W  = 24;
  localparam int unsigned OUT_W  = 112;

  // Controller to datapath commands
  typedef struct packed {
    logic load_byte;
    logic eval;
    logic check;
    logic div_start;
    logic div_sel;    // 0: tick/sample_rate, 1: tick/period
    logic q_sat;
    logic q_take;
    logic per_load;
    logic rate_take;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
    logic sr_zero;
    logic per_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/svx_header_checker.sv
// Top level of the 8SVX header checker: controller, datapath and ports.
//
// Header bytes are taken one per cycle on the slave stream, in file order, with
// tlast on the final byte. After a beat with tlast the block stops taking bytes
// while it evaluates the header: a result with status 1 to 5 needs no division;
// a good header runs two 24-step divisions (tick_rate by the sample rate, then
// tick_rate by the clamped period) on one shared bit-serial divider, skipping the
// first when the sample rate is zero. The result sits
// in an output register, so the next file's bytes are accepted while it waits.
module svx_header_checker
  import svxhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // header byte stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
  input  logic             s_axis_tlast,   // last
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [2:0] status, [3] stereo, [35:4] sample_count, [67:36] data_offset,
  // [83:68] period, [107:84] play_rate, [111:108] zero
  output logic [OUT_W-1:0] m_axis_tdata,
  // configuration writes: index 0 tick_rate, index 1 min_period
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [23:0]      cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  svxhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  svxhc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .byte_i      (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: hdl/svxhc_div.sv
// Restoring divider, one quotient bit per cycle.
module svxhc_div
  import svxhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic [DIV_W-1:0] rem_q, rem_d, quo_q, quo_d, dsr_q;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DIV_W:0]   rem_sh, diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one trial subtract per cycle
      if (!diff[DIV_W]) begin
        rem_d = diff[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) dsr_q <= divisor_i;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hdl/svxhc_dp.sv
// Datapath: header field capture, tag checks, result build, output register.
module svxhc_dp
  import svxhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic [7:0]       byte_i,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [23:0]      cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o
);

  // Configuration registers
  logic [23:0] tick_rate_q;
  logic [15:0] min_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q  <= TICK_RATE_RST;
      min_period_q <= MIN_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TICK_RATE:  tick_rate_q  <= cfg_data_i;
        CFG_MIN_PERIOD: min_period_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Parse state
  logic [7:0]  pos_q;
  logic [23:0] hist_q;
  logic        form_ok_q, voice_ok_q, chan_q, body_q;
  logic [31:0] form_len_q, one_shot_q, repeat_q;
  logic [15:0] srate_q;
  logic [7:0]  octave_q, comp_q;
  logic [31:0] word;

  assign word = {hist_q, byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hist_q     <= '0;
      form_ok_q  <= 1'b0;
      voice_ok_q <= 1'b0;
      chan_q     <= 1'b0;
      body_q     <= 1'b0;
      form_len_q <= '0;
      one_shot_q <= '0;
      repeat_q   <= '0;
      srate_q    <= '0;
      octave_q   <= '0;
      comp_q     <= '0;
    end else if (cmd_i.out_load) begin
      // back to the start for the next file
      pos_q      <= '0;
      hist_q     <= '0;
      form_ok_q  <= 1'b0;
      voice_ok_q <= 1'b0;
      chan_q     <= 1'b0;
      body_q     <= 1'b0;
      form_len_q <= '0;
      one_shot_q <= '0;
      repeat_q   <= '0;
      srate_q    <= '0;
      octave_q   <= '0;
      comp_q     <= '0;
    end else if (cmd_i.load_byte) begin
      if (pos_q < SCAN_END) begin
        if (pos_q == 8'd3)  form_ok_q  <= (word == TAG_FORM);
        if (pos_q == 8'd11) voice_ok_q <= (word == TAG_8SVX);
        if (pos_q == 8'd15) voice_ok_q <= voice_ok_q && (word == TAG_VHDR);
        if (pos_q >= 8'd4 && pos_q <= 8'd7)   form_len_q <= {form_len_q[23:0], byte_i};
        if (pos_q >= 8'd20 && pos_q <= 8'd23) one_shot_q <= {one_shot_q[23:0], byte_i};
        if (pos_q >= 8'd24 && pos_q <= 8'd27) repeat_q   <= {repeat_q[23:0], byte_i};
        if (pos_q >= 8'd32 && pos_q <= 8'd33) srate_q    <= {srate_q[7:0], byte_i};
        if (pos_q == 8'd34) octave_q <= byte_i;
        if (pos_q == 8'd35) comp_q   <= byte_i;
        // trailing area: channel and body tags until a body tag is seen
        if (pos_q >= TAG_FIRST && !body_q) begin
          if (word == TAG_CHAN) chan_q <= 1'b1;
          if (word == TAG_BODY) body_q <= 1'b1;
        end
        hist_q <= word[23:0];
      end
      if (pos_q != POS_MAX) pos_q <= pos_q + 8'd1;
    end
  end

  // Result computation
  logic [2:0]  status_q, status_d;
  logic        stereo_q;
  logic [31:0] count_q, base_q, offset_q, offset_d;
  logic [15:0] per_q, per_sat, per_d;
  logic [23:0] rate_q, qraw_q;
  logic        early;

  always_comb begin
    offset_d = base_q - (chan_q ? {count_q[30:0], 1'b0} : count_q);
    early    = 1'b1;
    priority if (!form_ok_q) begin
      status_d = ST_NOT_IFF;
    end else if (!(voice_ok_q && pos_q >= 8'd16)) begin
      status_d = ST_NOT_8SVX;
    end else if (comp_q != 8'd0) begin
      status_d = ST_COMPRESSED;
    end else if (octave_q != 8'd1) begin
      status_d = ST_OCTAVE;
    end else if (body_q && offset_d != 32'd0 && !offset_d[31]) begin
      status_d = ST_OK;
      early    = 1'b0;
    end else begin
      status_d = ST_BAD_LAYOUT;
      early    = 1'b0;
    end
  end

  // Period clamp: saturate to 16 bits, then raise to the minimum
  assign per_sat = (|qraw_q[23:16]) ? 16'hFFFF : qraw_q[15:0];
  assign per_d   = (per_sat < min_period_q) ? min_period_q : per_sat;

  // Shared divider
  logic [DIV_W-1:0] div_dvs, div_quo;
  logic             div_done;

  assign div_dvs = cmd_i.div_sel ? {8'd0, per_q} : {8'd0, srate_q};

  svxhc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (tick_rate_q),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      count_q <= one_shot_q + repeat_q;
      base_q  <= form_len_q + 32'd8;
      per_q   <= '0;
      rate_q  <= '0;
    end
    if (cmd_i.check) begin
      status_q <= status_d;
      stereo_q <= early ? 1'b0 : chan_q;
      count_q  <= early ? 32'd0 : count_q;
      offset_q <= early ? 32'd0 : offset_d;
    end
    if (cmd_i.q_sat)     qraw_q <= 24'h00FFFF;
    if (cmd_i.q_take)    qraw_q <= div_quo;
    if (cmd_i.per_load)  per_q  <= per_d;
    if (cmd_i.rate_take) rate_q <= div_quo;
  end

  // Output register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {4'd0, rate_q, per_q, offset_q, count_q, stereo_q, status_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    sts_o.need_div = (status_d == ST_OK);
    sts_o.sr_zero  = (srate_q == 16'd0);
    sts_o.per_zero = (per_q == 16'd0);
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

FILE: hdl/svxhc_ctrl.sv
// Controller: sequences byte intake, result evaluation and the two divisions.
module svxhc_ctrl
  import svxhc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV1  = 3'd3;
  localparam logic [2:0] S_PER   = 3'd4;
  localparam logic [2:0] S_RATE  = 3'd5;
  localparam logic [2:0] S_DIV2  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_byte = in_valid_i;
        if (in_valid_i && in_last_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (!sts_i.need_div) begin
          state_d = S_DONE;
        end else if (sts_i.sr_zero) begin
          cmd_o.q_sat = 1'b1;
          state_d     = S_PER;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.q_take = 1'b1;
          state_d      = S_PER;
        end
      end
      S_PER: begin
        cmd_o.per_load = 1'b1;
        state_d        = S_RATE;
      end
      S_RATE: begin
        if (sts_i.per_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts_i.div_done) begin
          cmd_o.rate_take = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
